[hw/rtl/moving_average_dc_filter_unit_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef MOVING_AVERAGE_DC_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_DC_FILTER_UNIT_MACROS_SVH

// ante holds at one edge, cons must hold at the next; skipped while in reset
`define MADCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("madcf: next-cycle check failed");

// checked across reset itself
`define MADCF_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("madcf: post-reset check failed");

`endif

[hw/rtl/madcf_pkg.sv]
package madcf_pkg;

   localparam int WINDOW_RESET = 64;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hw/rtl/madcf_if.sv]
interface madcf_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface madcf_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface madcf_csr_if #(parameter int LEN_BITS = 11);
   logic                valid;
   logic                ready;
   logic [LEN_BITS-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

[hw/rtl/madcf_ring.sv]
module madcf_ring #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/madcf_div.sv]
module madcf_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_W-1:0]    dividend,
   input  logic        [DEN_W-1:0]    divisor,
   output logic signed [NUM_W-1:0]    quotient,
   output madcf_pkg::div_status_type  status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             have_ff, have_in;
   logic             neg_ff, neg_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   partial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // restoring division on the magnitude, one quotient bit per cycle
   always_comb begin
      partial = {rem_ff, quo_ff[NUM_W-1]};
      diff    = partial - {1'b0, den_ff};
      fits    = partial >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      have_in = have_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = CNT_W'(NUM_W);
         have_in = 1'b1;
         neg_in  = dividend[NUM_W-1];
         quo_in  = dividend[NUM_W-1] ? (-dividend) : dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         have_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         have_ff <= have_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = neg_ff ? (-quo_ff) : quo_ff;
   assign status.busy = cnt_ff != '0;
   assign status.done = have_ff && (cnt_ff == '0);

endmodule

[hw/rtl/moving_average_dc_filter_unit.sv]
// An accepted input beat starts the one-bit-per-cycle divider for the window mean; the result
// beat is registered once the divider is done and the output register is free. A new sample
// is not taken until the previous one has committed its result.
// Reset: window 64, empty history, no result pending; ring contents are masked by a
// wrap flag, so no clearing pass runs. A window write clears the history the same way.
module moving_average_dc_filter_unit #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   madcf_req_if.sink      req_bus,
   madcf_rsp_if.source    rsp_bus,
   madcf_csr_if.sink      csr_bus
);

   localparam int POS_W     = $clog2(MAX_WINDOW);
   localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W     = SAMPLE_BITS + POS_W;
   localparam int OUT_W     = SAMPLE_BITS + 1;
   localparam int RESET_LEN = (madcf_pkg::WINDOW_RESET > MAX_WINDOW) ?
                              MAX_WINDOW : madcf_pkg::WINDOW_RESET;

   typedef enum logic {ST_IDLE, ST_DIV} state_type;

   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      wrapped_ff, wrapped_in;
   logic [LEN_W-1:0]          window_ff, window_in;

   logic                      req_accept;
   logic                      csr_accept;
   logic                      commit;
   logic [LEN_W-1:0]          cfg_len;
   logic [LEN_W-1:0]          pos_next;
   logic [SAMPLE_BITS-1:0]    rd_data;
   logic signed [SAMPLE_BITS-1:0] oldest;
   logic signed [SUM_W-1:0]   quotient;
   madcf_pkg::div_status_type div_status;

   assign csr_bus.ready = state_ff == ST_IDLE;
   assign req_bus.ready = (state_ff == ST_IDLE) && !csr_bus.valid;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_accept    = csr_bus.valid && csr_bus.ready;
   assign commit        = (state_ff == ST_DIV) && div_status.done &&
                          (!rsp_valid_ff || rsp_bus.ready);
   assign oldest        = wrapped_ff ? $signed(rd_data) : '0;
   assign pos_next      = LEN_W'(pos_ff) + 1'b1;

   always_comb begin
      if (csr_bus.window_length == '0) begin
         cfg_len = LEN_W'(1);
      end else if (csr_bus.window_length > LEN_W'(MAX_WINDOW)) begin
         cfg_len = LEN_W'(MAX_WINDOW);
      end else begin
         cfg_len = csr_bus.window_length;
      end
   end

   madcf_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (pos_ff),
      .rd_data (rd_data),
      .wr_en   (commit),
      .wr_addr (pos_ff),
      .wr_data (sample_ff)
   );

   madcf_div #(
      .NUM_W (SUM_W),
      .DEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend (sum_ff),
      .divisor  (window_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      sample_in    = sample_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      wrapped_in   = wrapped_ff;
      window_in    = window_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_accept) begin
               window_in  = cfg_len;
               sum_in     = '0;
               pos_in     = '0;
               wrapped_in = 1'b0;
            end else if (req_accept) begin
               sample_in = req_bus.sample_in;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quotient[OUT_W-1:0] - OUT_W'(oldest);
               sum_in       = sum_ff - SUM_W'(oldest) + SUM_W'(sample_ff);
               if (pos_next == window_ff) begin
                  pos_in     = '0;
                  wrapped_in = 1'b1;
               end else begin
                  pos_in = pos_next[POS_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         window_ff    <= LEN_W'(RESET_LEN);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         window_ff    <= window_in;
      end
      rsp_data_ff <= rsp_data_in;
      sample_ff   <= sample_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;

endmodule

[hw/rtl/madcf_checker.sv]
`include "moving_average_dc_filter_unit_macros.svh"

module madcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_valid,
   input logic csr_ready
);

   `MADCF_ASSERT_AFTER_RESET(a_no_rsp_after_reset, clock, reset, !rsp_valid)
   `MADCF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MADCF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready && !csr_ready)
   `MADCF_ASSERT_NEXT(a_idle_after_csr, clock, reset, csr_valid && csr_ready, csr_ready)

endmodule

bind moving_average_dc_filter_unit madcf_checker u_madcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);

[sim/dc_filter_compare.sv]
`timescale 1ns / 100ps

module dc_filter_compare #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int LEN_BITS    = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS:0]   rsp_sample,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [LEN_BITS-1:0]           csr_window,
   output int                            mismatches,
   output int                            outputs_waiting,
   output int                            outputs_checked
);

   localparam int PRINT_LIMIT = 40;

   logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
   logic signed [25:0]            history_sum;
   int unsigned                   head;
   int unsigned                   window;
   logic signed [SAMPLE_BITS:0]   pending_outputs [$];

   task automatic clear_history();
      for (int i = 0; i < MAX_WINDOW; i++) history[i] = '0;
      history_sum = '0;
      head = 0;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) $display("ERROR %0t: %s", $time, what);
      mismatches++;
   endtask

   // mean of the window (truncated toward zero) minus the sample being replaced
   task automatic predict_dc_removed(input logic signed [SAMPLE_BITS-1:0] sample,
                                     output logic signed [SAMPLE_BITS:0] dc_removed);
      logic signed [SAMPLE_BITS-1:0] oldest;
      longint                        mean;
      oldest = history[head];
      mean = longint'(history_sum) / longint'(window);
      dc_removed = (SAMPLE_BITS+1)'(mean - longint'(oldest));
      history_sum = history_sum - oldest + sample;
      history[head] = sample;
      head = (head + 1 >= window) ? 0 : head + 1;
   endtask

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS:0] predicted;
      logic signed [SAMPLE_BITS:0] oldest_expected;
      if (reset) begin
         window = madcf_pkg::WINDOW_RESET;
         clear_history();
         pending_outputs.delete();
         mismatches = 0;
         outputs_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_window == 0)
               window = 1;
            else if (csr_window > MAX_WINDOW)
               window = MAX_WINDOW;
            else
               window = int'(csr_window);
            clear_history();
         end
         if (req_valid && req_ready) begin
            predict_dc_removed(req_sample, predicted);
            pending_outputs.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("output beat %0d with nothing expected", rsp_sample));
            end else begin
               oldest_expected = pending_outputs.pop_front();
               outputs_checked++;
               if (rsp_sample !== oldest_expected)
                  report_mismatch($sformatf("sample_out %0d, expected %0d",
                                            rsp_sample, oldest_expected));
            end
         end
      end
      outputs_waiting <= pending_outputs.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_WINDOW       = 1024;
   localparam int SAMPLE_BITS      = 16;
   localparam int LEN_BITS         = 11;
   localparam int RESULT_LATENCY   = 27;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES           = 10;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_e;

   logic clock;
   logic reset;

   madcf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   madcf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   madcf_csr_if #(.LEN_BITS(LEN_BITS))       csr_bus ();

   int mismatches;
   int outputs_waiting;
   int outputs_checked;

   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   logic long_hold_request  = 1'b0;
   int   samples_sent       = 0;
   int   window_writes      = 0;
   int   dc_level           = 0;

   // -1 selects a random window length
   int phase_window [PHASES] = '{0, 1, 2, 5, 1025, 17, 64, 1024, 2047, -1};
   int phase_items  [PHASES] = '{30, 20, 30, 40, 1050, 60, 60, 30, 30, 60};

   moving_average_dc_filter_unit #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   dc_filter_compare #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .LEN_BITS   (LEN_BITS)
   ) i_compare (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_sample     (req_bus.sample_in),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_sample     (rsp_bus.sample_out),
      .csr_valid      (csr_bus.valid),
      .csr_ready      (csr_bus.ready),
      .csr_window     (csr_bus.window_length),
      .mismatches     (mismatches),
      .outputs_waiting(outputs_waiting),
      .outputs_checked(outputs_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Run timed out");
      $display("Mismatches found");
      $finish;
   end

   // output side: random stalls plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic set_traffic(input flow_mode_e mode);
      case (mode)
         FLOW_FREE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         FLOW_SENDER_IDLE: begin
            sender_idle_pct = 88;
            receiver_stall_pct = 0;
         end
         FLOW_RECEIVER_STALL: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 88;
         end
         default: begin
            sender_idle_pct = 15;
            receiver_stall_pct = 15;
         end
      endcase
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample_in = sample;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_for_outputs();
      @(negedge clock);
      req_bus.valid = 1'b0;
      do @(posedge clock); while (outputs_waiting != 0);
      repeat (RESULT_LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_window(input logic [LEN_BITS-1:0] length);
      wait_for_outputs();
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.window_length = length;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      window_writes++;
   endtask

   // full-scale extremes, DC level with small noise, or anything
   function automatic logic signed [SAMPLE_BITS-1:0] next_random_sample();
      int pick;
      int level;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3, 4: begin
            level = dc_level + $urandom_range(0, 200) - 100;
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            return SAMPLE_BITS'(level);
         end
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   initial begin
      logic signed [SAMPLE_BITS-1:0] directed [] = '{
         16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh7FFF, 16'sh7FFF,
         16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA, -16'sd2,
         16'sd2, -16'sd3, 16'sh0000, 16'sh7FFE, 16'sh8001, -16'sd100
      };
      int guard;
      req_bus.valid = 1'b0;
      req_bus.sample_in = '0;
      csr_bus.valid = 1'b0;
      csr_bus.window_length = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_traffic(FLOW_FREE);
      foreach (directed[i]) send_sample(directed[i]);

      // hold the output off while input keeps coming, so the input stalls
      long_hold_request = 1'b1;
      repeat (12) send_sample(next_random_sample());

      for (int p = 0; p < PHASES; p++) begin
         if (phase_window[p] < 0)
            write_window(LEN_BITS'($urandom_range(3, 200)));
         else
            write_window(LEN_BITS'(phase_window[p]));
         dc_level = $urandom_range(0, 65535) - 32768;
         for (int k = 0; k < phase_items[p]; k++) begin
            if (samples_sent % 40 == 0) set_traffic(flow_mode_e'((samples_sent / 40) % 4));
            send_sample(next_random_sample());
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (outputs_waiting != 0 && guard < 20000);
      repeat (2 * RESULT_LATENCY) @(posedge clock);

      $display("Sent %0d samples with %0d window writes (zero, one, oversized, full length),",
               samples_sent, window_writes);
      $display("checked %0d outputs under free, sparse, stalled and mixed traffic.",
               outputs_checked);
      if (outputs_waiting != 0)
         $display("ERROR: %0d expected outputs never arrived", outputs_waiting);
      if (mismatches == 0 && outputs_waiting == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
